[sv/lre_pkg.sv]
`timescale 1ns / 1ps

package lre_pkg;

    // fixed field widths
    localparam int MODE_W = 2;
    localparam int IIDX_W = 2;
    localparam int PIN_W  = 4;
    localparam int TIDX_W = 3;
    localparam int OIDX_W = 3;
    localparam int TIME_W = 32;
    localparam int COIL_W = 6;

    // instruction codes
    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NOT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AND  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_OR   = 2'd3;

    // one instruction word as held in the input register
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IIDX_W-1:0] input_index;
        logic              scan_start;
        logic [PIN_W-1:0]  pin_levels;
        logic              rung_end;
        logic              timer_enable;
        logic [TIDX_W-1:0] timer_index;
        logic [TIME_W-1:0] timer_preset;
        logic [OIDX_W-1:0] output_index;
        logic [TIME_W-1:0] now_ms;
    } lre_item_t;

    // rung status from the stack unit
    typedef struct packed {
        logic value;
        logic error;
    } lre_rung_t;

endpackage

[sv/ladder_rung_evaluator_core.sv]
// a result word is loaded into the result register when its rung end word leaves the input register
// throughput: one instruction word per cycle, set by the stack and timer update, except while a rung end word waits
// a rung end word waits in the input register only while the result register is full and out_ready is low
// reset: asynchronous, active low; clears stack, latched inputs, coils, timers and error
`timescale 1ns / 1ps

module ladder_rung_evaluator_core
    import lre_pkg::*;
#(
    parameter int STACK_DEPTH = 8,
    parameter int NUM_INPUTS  = 4,
    parameter int NUM_OUTPUTS = 6,
    parameter int NUM_TIMERS  = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [MODE_W-1:0] mode,
    input  logic [IIDX_W-1:0] input_index,
    input  logic              scan_start,
    input  logic [PIN_W-1:0]  pin_levels,
    input  logic              rung_end,
    input  logic              timer_enable,
    input  logic [TIDX_W-1:0] timer_index,
    input  logic [TIME_W-1:0] timer_preset,
    input  logic [OIDX_W-1:0] output_index,
    input  logic [TIME_W-1:0] now_ms,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              rung_value,
    output logic [OIDX_W-1:0] coil_index,
    output logic [COIL_W-1:0] coil_vector,
    output logic              stack_error
);

    lre_item_t item_reg;
    logic      s1_valid_reg;
    logic      advance;
    logic      emit;

    lre_rung_t rung;
    logic      timed;

    logic [NUM_OUTPUTS-1:0] coil_reg;
    logic [NUM_OUTPUTS-1:0] coil_next;
    logic [31:0]            coil_wide;
    logic [31:0]            coil_reg_wide;

    logic              out_valid_reg;
    logic              rung_value_reg;
    logic [OIDX_W-1:0] coil_index_reg;
    logic [COIL_W-1:0] coil_vector_reg;
    logic              stack_error_reg;

    // flow control: only a rung end word needs room in the result register
    assign advance  = s1_valid_reg && (!item_reg.rung_end || !out_valid_reg || out_ready);
    assign emit     = advance && item_reg.rung_end;
    assign in_ready = !s1_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.mode         <= mode;
            item_reg.input_index  <= input_index;
            item_reg.scan_start   <= scan_start;
            item_reg.pin_levels   <= pin_levels;
            item_reg.rung_end     <= rung_end;
            item_reg.timer_enable <= timer_enable;
            item_reg.timer_index  <= timer_index;
            item_reg.timer_preset <= timer_preset;
            item_reg.output_index <= output_index;
            item_reg.now_ms       <= now_ms;
        end
    end

    // bit stack
    lre_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .NUM_INPUTS  (NUM_INPUTS)
    ) u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .rung    (rung)
    );

    // on-delay timers
    lre_timer #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_timer (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .level   (rung.value),
        .value   (timed)
    );

    // coil write, out of range index leaves coils alone
    always_comb
    begin
        coil_next = coil_reg;
        for (int i = 0; i < NUM_OUTPUTS; i++)
        begin
            if (32'(item_reg.output_index) == i)
            begin
                coil_next[i] = timed;
            end
        end
    end

    assign coil_wide     = 32'(coil_next);
    assign coil_reg_wide = 32'(coil_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coil_reg <= '0;
        end
        else if (emit)
        begin
            coil_reg <= coil_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            rung_value_reg  <= timed;
            coil_index_reg  <= item_reg.output_index;
            coil_vector_reg <= coil_wide[COIL_W-1:0];
            stack_error_reg <= rung.error;
        end
    end

    assign out_valid   = out_valid_reg;
    assign rung_value  = rung_value_reg;
    assign coil_index  = coil_index_reg;
    assign coil_vector = coil_vector_reg;
    assign stack_error = stack_error_reg;

`ifndef SYNTHESIS
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("rung end word produced no result");

    a_coil_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (coil_vector_reg == coil_reg_wide[COIL_W-1:0]))
        else $error("pending coil word differs from coil register");

    a_rung_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && item_reg.rung_end && out_valid_reg && !out_ready)
        |=> (s1_valid_reg && $stable(item_reg)))
        else $error("stalled rung end word lost");
`endif

endmodule

[sv/lre_stack.sv]
`timescale 1ns / 1ps

module lre_stack
    import lre_pkg::*;
#(
    parameter int STACK_DEPTH = 8,
    parameter int NUM_INPUTS  = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  lre_item_t item,
    output lre_rung_t rung
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    logic [STACK_DEPTH-1:0] stack_reg;
    logic [STACK_DEPTH-1:0] stack_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [PIN_W-1:0]       latch_reg;
    logic [PIN_W-1:0]       latch_next;
    logic                   err_reg;
    logic                   err_next;

    logic             push_bit;
    logic             top_bit;
    logic             sec_bit;
    logic             is_full;
    logic             has_one;
    logic             has_two;
    logic             wr_en;
    logic             wr_bit;
    logic [CNT_W-1:0] wr_pos;

    // input latch, active-low pins inverted
    assign latch_next = item.scan_start ? ~item.pin_levels : latch_reg;
    assign push_bit   = (32'(item.input_index) < NUM_INPUTS) ? latch_next[item.input_index]
                                                             : 1'b0;

    // top and second entries
    always_comb
    begin
        top_bit = 1'b0;
        sec_bit = 1'b0;
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            if (32'(count_reg) == i + 1)
            begin
                top_bit = stack_reg[i];
            end
            if (32'(count_reg) == i + 2)
            begin
                sec_bit = stack_reg[i];
            end
        end
    end

    assign is_full = 32'(count_reg) >= STACK_DEPTH;
    assign has_one = count_reg != '0;
    assign has_two = count_reg > CNT_W'(1);

    // instruction decode, faults leave the stack alone
    always_comb
    begin
        wr_en      = 1'b0;
        wr_bit     = 1'b0;
        wr_pos     = count_reg;
        count_next = count_reg;
        err_next   = err_reg;
        unique case (item.mode)
            MODE_PUSH:
            begin
                if (is_full)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_bit     = push_bit;
                    wr_pos     = count_reg;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            MODE_NOT:
            begin
                if (!has_one)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    wr_en  = 1'b1;
                    wr_bit = ~top_bit;
                    wr_pos = count_reg - CNT_W'(1);
                end
            end
            MODE_AND, MODE_OR:
            begin
                if (!has_two)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_bit     = (item.mode == MODE_AND) ? (sec_bit & top_bit)
                                                         : (sec_bit | top_bit);
                    wr_pos     = count_reg - CNT_W'(2);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                err_next = err_reg;
            end
        endcase
    end

    // entry write
    always_comb
    begin
        stack_next = stack_reg;
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            if (wr_en && (32'(wr_pos) == i))
            begin
                stack_next[i] = wr_bit;
            end
        end
    end

    // rung result is the bottom entry
    assign rung.value = (count_next != '0) ? stack_next[0] : 1'b0;
    assign rung.error = err_next;

    // state update, count and error cleared at rung end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_reg <= '0;
            count_reg <= '0;
            latch_reg <= '0;
            err_reg   <= 1'b0;
        end
        else if (advance)
        begin
            stack_reg <= stack_next;
            latch_reg <= latch_next;
            count_reg <= item.rung_end ? '0 : count_next;
            err_reg   <= item.rung_end ? 1'b0 : err_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= STACK_DEPTH)
        else $error("stack count beyond depth");

    a_rung_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item.rung_end) |=> (count_reg == '0) && !err_reg)
        else $error("stack not cleared after rung end");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !item.rung_end && rung.error) |=> err_reg)
        else $error("stack error lost within rung");
`endif

endmodule

[sv/lre_timer.sv]
`timescale 1ns / 1ps

module lre_timer
    import lre_pkg::*;
#(
    parameter int NUM_TIMERS = 6
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  lre_item_t item,
    input  logic      level,
    output logic      value
);

    logic [TIME_W-1:0] start_reg [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] run_reg;

    logic              use_timer;
    logic [TIME_W-1:0] sel_start;
    logic              sel_run;
    logic [TIME_W-1:0] elapsed;

    assign use_timer = item.rung_end && item.timer_enable
                       && (32'(item.timer_index) < NUM_TIMERS);

    // selected timer
    always_comb
    begin
        sel_start = '0;
        sel_run   = 1'b0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            if (32'(item.timer_index) == i)
            begin
                sel_start = start_reg[i];
                sel_run   = run_reg[i];
            end
        end
    end

    // wrapping elapsed time against preset
    assign elapsed = item.now_ms - sel_start;

    always_comb
    begin
        priority if (!use_timer)
        begin
            value = level;
        end
        else if (!level)
        begin
            value = 1'b0;
        end
        else if (!sel_run)
        begin
            value = (item.timer_preset == '0);
        end
        else
        begin
            value = (elapsed >= item.timer_preset);
        end
    end

    // timer start and stop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                start_reg[i] <= '0;
            end
        end
        else if (advance && use_timer)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                if (32'(item.timer_index) == i)
                begin
                    if (!level)
                    begin
                        run_reg[i] <= 1'b0;
                    end
                    else if (!run_reg[i])
                    begin
                        run_reg[i]   <= 1'b1;
                        start_reg[i] <= item.now_ms;
                    end
                end
            end
        end
    end

endmodule
